[src/c8ic_pkg.sv]
`timescale 1ns / 1ps
package c8ic_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int FONT_BYTES  = 80;

  localparam int AW     = $clog2(MEM_BYTES);
  localparam int ROW_AW = $clog2(SCREEN_H);
  localparam int COL_W  = $clog2(SCREEN_W);
  localparam int SP_IW  = $clog2(STACK_DEPTH);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);

  localparam logic [AW-1:0] PC_RESET = AW'(12'h200);

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_EXEC  = 2'd1,
    FN_ROW   = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_FULL  = 2'd1;
  localparam logic [1:0] FLT_EMPTY = 2'd2;

  // opcode high nibble
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  localparam logic [7:0] F_GETDLY  = 8'h07;
  localparam logic [7:0] F_WAITKEY = 8'h0A;
  localparam logic [7:0] F_SETDLY  = 8'h15;
  localparam logic [7:0] F_SETSND  = 8'h18;
  localparam logic [7:0] F_ADDIDX  = 8'h1E;
  localparam logic [7:0] F_FONT    = 8'h29;
  localparam logic [7:0] F_BCD     = 8'h33;
  localparam logic [7:0] F_STORE   = 8'h55;
  localparam logic [7:0] F_LOAD    = 8'h65;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
  };

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ROW,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_EXEC,
    S_RET, S_VF, S_DRD, S_DWR, S_BCD1, S_BCD2,
    S_STRD, S_STWR, S_LDRD, S_LDWR, S_DONE
  } state_t;

endpackage

[src/c8ic_if.sv]
`timescale 1ns / 1ps
interface c8ic_req_if;
  import c8ic_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    func;
  logic [AW-1:0] addr;
  logic [7:0]    data_byte;
  logic [15:0]   key_states;
  logic [7:0]    random_byte;

  modport source(output valid, func, addr, data_byte, key_states, random_byte,
                 input ready);
  modport sink(input valid, func, addr, data_byte, key_states, random_byte,
               output ready);
endinterface

interface c8ic_rsp_if;
  import c8ic_pkg::*;
  logic                valid;
  logic                ready;
  logic [AW-1:0]       pc_out;
  logic [SCREEN_W-1:0] row_bits;
  logic [7:0]          delay_value;
  logic [7:0]          sound_value;
  logic                waiting_key;
  logic [1:0]          fault;

  modport source(output valid, pc_out, row_bits, delay_value, sound_value, waiting_key,
                 fault, input ready);
  modport sink(input valid, pc_out, row_bits, delay_value, sound_value, waiting_key,
               fault, output ready);
endinterface

[src/c8ic_ram.sv]
`timescale 1ns / 1ps
module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/chip8_instruction_core.sv]
`timescale 1ns / 1ps
// One transaction in flight; the result register lets the next one enter while a result waits.
// Reset is synchronous; afterwards a pass over every main-memory address loads the font
// and clears main memory before the first transaction is accepted.
module chip8_instruction_core (
  input logic       clk,
  input logic       rst,
  c8ic_req_if.sink  req,
  c8ic_rsp_if.source rsp
);
  import c8ic_pkg::*;

  state_t state, state_next;

  logic [1:0]          func_q;
  logic [AW-1:0]       addr_q;
  logic [15:0]         keys_q;
  logic [7:0]          rnd_q;
  logic [15:0]         op;
  logic [7:0]          vx, vy;
  logic [AW-1:0]       pc, idx;
  logic [SP_W-1:0]     sp;
  logic [7:0]          dly, snd;
  logic [3:0]          cnt;
  logic                hit, flag_q, wait_q;
  logic [1:0]          fault_q;
  logic [SCREEN_W-1:0] row_q;
  logic [AW-1:0]       clr_addr;
  logic [SCREEN_H-1:0] disp_valid;
  logic [15:0]         v_valid;
  logic                disp_rvalid, v_rvalid;

  logic                rsp_valid;
  logic [AW-1:0]       out_pc;
  logic [SCREEN_W-1:0] out_row;
  logic [7:0]          out_dly, out_snd;
  logic                out_wait;
  logic [1:0]          out_fault;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata, mem_rd;
  logic                disp_we;
  logic [ROW_AW-1:0]   disp_waddr, disp_raddr;
  logic [SCREEN_W-1:0] disp_wdata, disp_rd;
  logic                v_we;
  logic [3:0]          v_waddr, v_raddr;
  logic [7:0]          v_wdata, v_rd;
  logic                stk_we;
  logic [SP_IW-1:0]    stk_waddr, stk_raddr;
  logic [AW-1:0]       stk_wdata, stk_rd;

  c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata), .raddr(mem_raddr),
    .rdata(mem_rd));
  c8ic_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_disp (
    .clk, .we(disp_we), .waddr(disp_waddr), .wdata(disp_wdata), .raddr(disp_raddr),
    .rdata(disp_rd));
  c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rd));
  c8ic_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata), .raddr(stk_raddr),
    .rdata(stk_rd));

  // decode
  logic [3:0]    hi, x, y, n;
  logic [7:0]    kk;
  logic [AW-1:0] nnn;
  assign hi  = op[15:12];
  assign x   = op[11:8];
  assign y   = op[7:4];
  assign n   = op[3:0];
  assign kk  = op[7:0];
  assign nnn = op[AW-1:0];

  logic accept, out_free;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid & req.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  logic [7:0]          v_data;
  logic [SCREEN_W-1:0] disp_data;
  assign v_data    = v_rvalid ? v_rd : 8'd0;
  assign disp_data = disp_rvalid ? disp_rd : '0;

  logic [AW-1:0] pc2, pc4;
  assign pc2 = pc + AW'(2);
  assign pc4 = pc + AW'(4);

  // ALU for 8xyN
  logic [7:0] alu_res;
  logic       alu_flag, alu_wr, alu_flagged;
  logic [8:0] sum9;
  assign sum9 = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    alu_res     = vx;
    alu_flag    = 1'b0;
    alu_wr      = 1'b1;
    alu_flagged = 1'b1;
    unique case (n)
      ALU_MOV:  begin alu_res = vy;      alu_flagged = 1'b0; end
      ALU_OR:   begin alu_res = vx | vy; alu_flagged = 1'b0; end
      ALU_AND:  begin alu_res = vx & vy; alu_flagged = 1'b0; end
      ALU_XOR:  begin alu_res = vx ^ vy; alu_flagged = 1'b0; end
      ALU_ADD:  begin alu_res = sum9[7:0]; alu_flag = sum9[8]; end
      ALU_SUB:  begin alu_res = vx - vy; alu_flag = (vx >= vy); end
      ALU_SHR:  begin alu_res = {1'b0, vx[7:1]}; alu_flag = vx[0]; end
      ALU_SUBN: begin alu_res = vy - vx; alu_flag = (vy >= vx); end
      ALU_SHL:  begin alu_res = {vx[6:0], 1'b0}; alu_flag = vx[7]; end
      default:  begin alu_wr = 1'b0; alu_flagged = 1'b0; end
    endcase
  end

  // keys
  logic       key_hit;
  logic [3:0] key_idx;
  assign key_hit = keys_q[vx[3:0]];
  always_comb begin
    key_idx = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[4'(k)]) key_idx = 4'(k);
    end
  end

  // BCD digits; tens by reciprocal multiply (exact below 1029)
  logic [1:0]  bcd_h;
  logic [6:0]  bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic [6:0]  bcd_o;
  always_comb begin
    if (vx >= 8'd200) begin
      bcd_h   = 2'd2;
      bcd_rem = 7'(vx - 8'd200);
    end else if (vx >= 8'd100) begin
      bcd_h   = 2'd1;
      bcd_rem = 7'(vx - 8'd100);
    end else begin
      bcd_h   = 2'd0;
      bcd_rem = vx[6:0];
    end
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = bcd_rem - 7'(bcd_t) * 7'd10;
  end

  // sprite row placement with horizontal wrap
  logic [ROW_AW-1:0]     draw_row;
  logic [AW-1:0]         idx_cnt;
  logic [SCREEN_W-1:0]   sprite_word, draw_mask;
  logic [2*SCREEN_W-1:0] sprite_rot;
  logic                  draw_hit, draw_last;
  assign draw_row    = vy[ROW_AW-1:0] + ROW_AW'(cnt);
  assign idx_cnt     = idx + AW'(cnt);
  assign sprite_word = {mem_rd, {(SCREEN_W-8){1'b0}}};
  assign sprite_rot  = {sprite_word, sprite_word} >> vx[COL_W-1:0];
  assign draw_mask   = sprite_rot[SCREEN_W-1:0];
  assign draw_hit    = |(disp_data & draw_mask);
  assign draw_last   = ({1'b0, cnt} + 5'd1) == {1'b0, n};

  logic [AW-1:0] font_addr;
  assign font_addr = AW'({vx, 2'b00}) + AW'(vx);

  // pc after the executed instruction
  logic [AW-1:0] pc_next;
  always_comb begin
    pc_next = pc2;
    unique case (hi)
      OP_JP:   pc_next = nnn;
      OP_CALL: if (sp < SP_W'(STACK_DEPTH)) pc_next = nnn;
      OP_SE:   if (vx == kk) pc_next = pc4;
      OP_SNE:  if (vx != kk) pc_next = pc4;
      OP_SER:  if (vx == vy) pc_next = pc4;
      OP_SNER: if (vx != vy) pc_next = pc4;
      OP_JPV0: pc_next = nnn + AW'(vy);
      OP_KEY: begin
        if ((kk == KEY_DOWN && key_hit) || (kk == KEY_UP && !key_hit)) pc_next = pc4;
      end
      OP_MISC: if (kk == F_WAITKEY && keys_q == 16'd0) pc_next = pc;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_addr == AW'(MEM_BYTES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (func_t'(req.func))
            FN_EXEC: state_next = S_F0;
            FN_ROW:  state_next = S_ROW;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ROW: state_next = S_DONE;
      S_F0:  state_next = S_F1;
      S_F1:  state_next = S_F2;
      S_F2:  state_next = S_F3;
      S_F3:  state_next = S_F4;
      S_F4:  state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_DONE;
        unique case (hi)
          OP_SYS:  if (op == OP_RET && sp != '0) state_next = S_RET;
          OP_ALU:  if (alu_flagged) state_next = S_VF;
          OP_DRW:  state_next = (n == 4'd0) ? S_VF : S_DRD;
          OP_MISC: begin
            if (kk == F_BCD)        state_next = S_BCD1;
            else if (kk == F_STORE) state_next = S_STRD;
            else if (kk == F_LOAD)  state_next = S_LDRD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RET:  state_next = S_DONE;
      S_VF:   state_next = S_DONE;
      S_DRD:  state_next = S_DWR;
      S_DWR:  state_next = draw_last ? S_VF : S_DRD;
      S_BCD1: state_next = S_BCD2;
      S_BCD2: state_next = S_DONE;
      S_STRD: state_next = S_STWR;
      S_STWR: state_next = (cnt == x) ? S_DONE : S_STRD;
      S_LDRD: state_next = S_LDWR;
      S_LDWR: state_next = (cnt == x) ? S_DONE : S_LDRD;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = 8'd0;
    mem_raddr  = pc;
    disp_we    = 1'b0;
    disp_waddr = draw_row;
    disp_wdata = disp_data ^ draw_mask;
    disp_raddr = draw_row;
    v_we       = 1'b0;
    v_waddr    = x;
    v_wdata    = 8'd0;
    v_raddr    = x;
    stk_we     = 1'b0;
    stk_waddr  = sp[SP_IW-1:0];
    stk_wdata  = pc;
    stk_raddr  = SP_IW'(sp - SP_W'(1));
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = (clr_addr < AW'(FONT_BYTES)) ? FONT[clr_addr[6:0]] : 8'd0;
      end
      S_IDLE: begin
        disp_raddr = req.addr[ROW_AW-1:0];
        if (accept && func_t'(req.func) == FN_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = req.addr;
          mem_wdata = req.data_byte;
        end
      end
      S_F0: mem_raddr = pc;
      S_F1: mem_raddr = pc + AW'(1);
      S_F2: v_raddr = x;
      S_F3: v_raddr = (hi == OP_JPV0) ? 4'd0 : y;
      S_EXEC: begin
        unique case (hi)
          OP_CALL: stk_we = (sp < SP_W'(STACK_DEPTH));
          OP_LD:   begin v_we = 1'b1; v_wdata = kk; end
          OP_ADD:  begin v_we = 1'b1; v_wdata = vx + kk; end
          OP_ALU:  begin v_we = alu_wr; v_wdata = alu_res; end
          OP_RND:  begin v_we = 1'b1; v_wdata = rnd_q & kk; end
          OP_MISC: begin
            if (kk == F_GETDLY) begin
              v_we = 1'b1; v_wdata = dly;
            end else if (kk == F_WAITKEY) begin
              v_we = (keys_q != 16'd0); v_wdata = {4'd0, key_idx};
            end else if (kk == F_BCD) begin
              mem_we = 1'b1; mem_waddr = idx; mem_wdata = {6'd0, bcd_h};
            end
          end
          default: ;
        endcase
      end
      S_VF: begin
        v_we = 1'b1; v_waddr = 4'hF; v_wdata = {7'd0, flag_q};
      end
      S_DRD: mem_raddr = idx_cnt;
      S_DWR: disp_we = 1'b1;
      S_BCD1: begin
        mem_we = 1'b1; mem_waddr = idx + AW'(1); mem_wdata = {4'd0, bcd_t};
      end
      S_BCD2: begin
        mem_we = 1'b1; mem_waddr = idx + AW'(2); mem_wdata = {4'd0, bcd_o[3:0]};
      end
      S_STRD: v_raddr = cnt;
      S_STWR: begin
        mem_we = 1'b1; mem_waddr = idx_cnt; mem_wdata = v_data;
      end
      S_LDRD: mem_raddr = idx_cnt;
      S_LDWR: begin
        v_we = 1'b1; v_waddr = cnt; v_wdata = mem_rd;
      end
      default: ;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      pc         <= PC_RESET;
      idx        <= '0;
      sp         <= '0;
      dly        <= 8'd0;
      snd        <= 8'd0;
      disp_valid <= '0;
      v_valid    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      disp_rvalid <= disp_valid[disp_raddr];
      v_rvalid    <= v_valid[v_raddr];
      if (v_we) v_valid[v_waddr] <= 1'b1;
      if (disp_we) disp_valid[disp_waddr] <= 1'b1;

      unique case (state)
        S_CLR: clr_addr <= clr_addr + AW'(1);
        S_IDLE: begin
          if (accept) begin
            func_q  <= req.func;
            addr_q  <= req.addr;
            keys_q  <= req.key_states;
            rnd_q   <= req.random_byte;
            wait_q  <= 1'b0;
            fault_q <= FLT_NONE;
            row_q   <= '0;
          end
        end
        S_ROW: if (addr_q < AW'(SCREEN_H)) row_q <= disp_data;
        S_F1: op[15:8] <= mem_rd;
        S_F2: op[7:0]  <= mem_rd;
        S_F3: vx <= v_data;
        S_F4: vy <= v_data;
        S_EXEC: begin
          pc <= pc_next;
          unique case (hi)
            OP_SYS: begin
              if (op == OP_CLS) disp_valid <= '0;
              if (op == OP_RET) begin
                if (sp == '0) fault_q <= FLT_EMPTY;
                else sp <= sp - SP_W'(1);
              end
            end
            OP_CALL: begin
              if (sp < SP_W'(STACK_DEPTH)) begin
                sp <= sp + SP_W'(1);
              end else begin
                fault_q <= FLT_FULL;
              end
            end
            OP_ALU:  flag_q <= alu_flag;
            OP_LDI:  idx <= nnn;
            OP_DRW: begin
              cnt    <= 4'd0;
              hit    <= 1'b0;
              flag_q <= 1'b0;
            end
            OP_MISC: begin
              cnt <= 4'd0;
              if (kk == F_WAITKEY) begin
                if (keys_q == 16'd0) wait_q <= 1'b1;
              end else if (kk == F_SETDLY) begin
                dly <= vx;
              end else if (kk == F_SETSND) begin
                snd <= vx;
              end else if (kk == F_ADDIDX) begin
                idx <= idx + AW'(vx);
              end else if (kk == F_FONT) begin
                if (vx < 8'd16) idx <= font_addr;
              end
            end
            default: ;
          endcase
        end
        S_RET: pc <= stk_rd + AW'(2);
        S_DWR: begin
          hit    <= hit | draw_hit;
          flag_q <= hit | draw_hit;
          cnt    <= cnt + 4'd1;
        end
        S_STWR: begin
          if (cnt == x) idx <= idx + AW'(x) + AW'(1);
          else cnt <= cnt + 4'd1;
        end
        S_LDWR: cnt <= cnt + 4'd1;
        default: ;
      endcase

      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
        out_pc    <= pc;
        out_row   <= row_q;
        out_dly   <= dly;
        out_snd   <= snd;
        out_wait  <= wait_q;
        out_fault <= fault_q;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.pc_out      = out_pc;
  assign rsp.row_bits    = out_row;
  assign rsp.delay_value = out_dly;
  assign rsp.sound_value = out_snd;
  assign rsp.waiting_key = out_wait;
  assign rsp.fault       = out_fault;

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("second transaction taken while busy");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !req.ready)
    else $error("transaction accepted during memory clear");

  a_fault_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && fault_q != FLT_NONE) |-> (func_q == FN_EXEC))
    else $error("fault reported for non-execute transaction");

  a_keywait_holds_pc: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && hi == OP_MISC && kk == F_WAITKEY && keys_q == 16'd0)
      |=> $stable(pc))
    else $error("pc moved during key wait");

endmodule
